FILE: hdl/sed_pkg.sv
// ---------------------------------------------------------------------------
// sed_pkg: shared constants for the Sobel edge detector
// Frame limits, field widths, register indexes, luma weights and square-root unit sizing.
// ---------------------------------------------------------------------------
package sed_pkg;

  // Largest frame the line stores and counters are sized for.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 2048;
  localparam int MIN_DIM    = 3;

  localparam int PIX_W = 8;
  localparam int COL_W = $clog2(MAX_WIDTH);
  // The row counter runs up to the height plus one while the last row drains.
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int WID_W = 11;
  localparam int HGT_W = 12;
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_LEVEL   = 2'd2;

  // Luma weights in Q16.
  localparam logic [23:0] W_RED   = 24'd19589;
  localparam logic [23:0] W_GREEN = 24'd38470;
  localparam logic [23:0] W_BLUE  = 24'd7471;

  // Square-root unit: a 17-bit operand padded to ten bit pairs, two pairs
  // retired per cycle.
  localparam int ROOT_OP_W  = 17;
  localparam int ROOT_PAD_W = 20;
  localparam int ROOT_W     = 10;
  localparam int ROOT_REM_W = 12;
  localparam int ROOT_ACC_W = ROOT_REM_W + 2;
  localparam int ROOT_PAIRS = 2;
  localparam int ROOT_ITER  = ROOT_PAD_W / (2 * ROOT_PAIRS);
  localparam int ROOT_CNT_W = $clog2(ROOT_ITER + 1);

endpackage

FILE: hdl/sobel_edge_detector.sv
// ---------------------------------------------------------------------------
// sobel_edge_detector: streaming 3x3 Sobel edge detector
// Converts RGB pixels to gray, keeps two lines in a block memory, applies
// both Sobel kernels with zero padding and reports gradients, magnitude and
// an edge flag per pixel.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------
//   in      | sink      | in_valid / in_stall    | req_type, red, green, blue
//   out     | source    | out_valid / out_stall  | grad_x_abs, grad_y_abs,
//           |           |                        | magnitude, edge_res, frame_last
//   cfg     | sink      | cfg_we (no wait)       | cfg_index, cfg_data
//
// An input transaction that yields no result passes the gray and window steps;
// one that yields a result also passes the gradient, square, square-root and
// done steps, the square-root unit running five iterations of two root bits each.
// Reset is synchronous and active high; it clears the counters, the window,
// the sequencer and the output valid. The line memory is not cleared.
// The output register lets a new input transaction be taken while a result
// still waits on out_stall; the sequencer only blocks at its final step when
// that register is still full.
// ---------------------------------------------------------------------------
module sobel_edge_detector import sed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // input pixel channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 req_type,
  input  logic [PIX_W-1:0]     red,
  input  logic [PIX_W-1:0]     green,
  input  logic [PIX_W-1:0]     blue,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     grad_x_abs,
  output logic [PIX_W-1:0]     grad_y_abs,
  output logic [PIX_W-1:0]     magnitude,
  output logic                 edge_res,
  output logic                 frame_last,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_GRAY = 7'b0000010,
    S_WIN  = 7'b0000100,
    S_GRAD = 7'b0001000,
    S_SQ   = 7'b0010000,
    S_ROOT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // What the accept cycle learns about the transaction and the pixel whose
  // neighborhood it completes.
  typedef struct packed {
    logic             flush;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [COL_W-1:0] col;
    logic             valid;
    logic             last;
    logic             top_z;
    logic             bot_z;
    logic             left_z;
    logic             right_z;
  } tag_t;

  state_t state;
  state_t state_next;

  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic [PIX_W-1:0] edge_level;
  logic [WID_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count_next;
  logic [ROW_W-1:0] row_count_next;

  logic             accept;
  logic             ignore;
  logic             geom_wr;
  logic             col_nz;
  logic             row_ok;
  logic [COL_W-1:0] qcol;
  logic [ROW_W-1:0] qrow;
  logic [WID_W-1:0] col_inc;
  tag_t             tag_now;
  tag_t             tag_q;

  logic [23:0]        gray_sum;
  logic [PIX_W-1:0]   gray_q;
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q;
  logic               mem_rd;
  logic               mem_wr;

  logic [PIX_W-1:0] win [3][3];
  logic [PIX_W-1:0] tap [3][3];
  logic [PIX_W+1:0] sum_l;
  logic [PIX_W+1:0] sum_r;
  logic [PIX_W+1:0] sum_t;
  logic [PIX_W+1:0] sum_b;
  logic [PIX_W-1:0] ax_q;
  logic [PIX_W-1:0] ay_q;
  logic [2*PIX_W-1:0] ax_sq;
  logic [2*PIX_W-1:0] ay_sq;
  logic [ROOT_OP_W-1:0] sq_sum;

  logic              root_start;
  logic              root_done;
  logic [ROOT_W-1:0] root_rnd;
  logic [PIX_W-1:0]  mag_q;
  logic              out_free;

  // Rounded |p - n| / 4; the difference never exceeds 1020.
  function automatic logic [PIX_W-1:0] quarter_abs(input logic [PIX_W+1:0] p,
                                                   input logic [PIX_W+1:0] n);
    logic [PIX_W+1:0] d;
    logic [PIX_W+2:0] s;
    d = (p >= n) ? (p - n) : (n - p);
    s = {1'b0, d} + (PIX_W+3)'(2);
    return s[PIX_W+1:2];
  endfunction

  // -------------------------------------------------------------------------
  // Configuration registers. Geometry outside the supported range is clamped
  // where it is used.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WID_W'(640);
      image_height <= HGT_W'(480);
      edge_level   <= PIX_W'(128);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HGT_W-1:0];
        REG_EDGE_LEVEL:   edge_level   <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width < WID_W'(MIN_DIM)) begin
      eff_w = WID_W'(MIN_DIM);
    end else if (image_width > WID_W'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = image_width;
    end
    if (image_height < HGT_W'(MIN_DIM)) begin
      eff_h = HGT_W'(MIN_DIM);
    end else if (image_height > HGT_W'(MAX_HEIGHT)) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = image_height;
    end
  end

  assign geom_wr = cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // -------------------------------------------------------------------------
  // Accept cycle: the arriving transaction completes the neighborhood of the
  // pixel one row and one column behind it. Work out that pixel's position,
  // its border flags, and the counters for the next transaction.
  // -------------------------------------------------------------------------
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  // A flush with nothing in flight has no effect at all.
  assign ignore   = req_type && (col_count == '0) && (row_count == '0);

  always_comb begin
    col_nz  = (col_count != '0);
    qcol    = col_nz ? (col_count - COL_W'(1)) : COL_W'(eff_w - WID_W'(1));
    row_ok  = col_nz ? (row_count >= ROW_W'(1)) : (row_count >= ROW_W'(2));
    qrow    = col_nz ? (row_count - ROW_W'(1)) : (row_count - ROW_W'(2));

    tag_now.flush   = req_type || (row_count >= ROW_W'(eff_h));
    tag_now.red     = red;
    tag_now.green   = green;
    tag_now.blue    = blue;
    tag_now.col     = col_count;
    tag_now.valid   = row_ok && (qrow < ROW_W'(eff_h));
    tag_now.top_z   = (qrow == '0);
    tag_now.bot_z   = (qrow == ROW_W'(eff_h - HGT_W'(1)));
    tag_now.left_z  = (qcol == '0);
    tag_now.right_z = ({1'b0, qcol} == (eff_w - WID_W'(1)));
    tag_now.last    = tag_now.bot_z && tag_now.right_z;

    col_inc = {1'b0, col_count} + WID_W'(1);
    if (tag_now.valid && tag_now.last) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (col_inc >= eff_w) begin
      col_count_next = '0;
      row_count_next = row_count + ROW_W'(1);
    end else begin
      col_count_next = col_inc[COL_W-1:0];
      row_count_next = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geom_wr) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept && !ignore) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !ignore) begin
      tag_q <= tag_now;
    end
  end

  // -------------------------------------------------------------------------
  // Line memory: each entry holds the two rows above the current one at that
  // column. It is read on accept and written back, shifted by one row, in the
  // window step, before the sequencer returns to idle and takes the next
  // transaction, so a read never meets a pending write to the same entry.
  // -------------------------------------------------------------------------
  assign mem_rd = accept && !ignore;
  assign mem_wr = (state == S_WIN);

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      mem_q <= line_mem[col_count];
    end
    if (mem_wr) begin
      line_mem[tag_q.col] <= {mem_q[PIX_W-1:0], gray_q};
    end
  end

  // Gray conversion with truncation; flushes and pixels past the frame's
  // last row enter as zero.
  assign gray_sum = W_RED * {16'd0, tag_q.red} + W_GREEN * {16'd0, tag_q.green}
                  + W_BLUE * {16'd0, tag_q.blue};

  always_ff @(posedge clk) begin
    if (state == S_GRAY) begin
      gray_q <= tag_q.flush ? '0 : gray_sum[23:16];
    end
  end

  // 3x3 window: rows are top, middle and the current line; column 2 is the
  // newest.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          win[a][b] <= '0;
        end
      end
    end else if (state == S_WIN) begin
      for (int a = 0; a < 3; a++) begin
        win[a][0] <= win[a][1];
        win[a][1] <= win[a][2];
      end
      win[0][2] <= mem_q[2*PIX_W-1:PIX_W];
      win[1][2] <= mem_q[PIX_W-1:0];
      win[2][2] <= gray_q;
    end
  end

  // -------------------------------------------------------------------------
  // Gradients: taps outside the frame read as zero.
  // -------------------------------------------------------------------------
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        if ((a == 0 && tag_q.top_z) || (a == 2 && tag_q.bot_z) ||
            (b == 0 && tag_q.left_z) || (b == 2 && tag_q.right_z)) begin
          tap[a][b] = '0;
        end else begin
          tap[a][b] = win[a][b];
        end
      end
    end
    sum_r = {2'b00, tap[0][2]} + {1'b0, tap[1][2], 1'b0} + {2'b00, tap[2][2]};
    sum_l = {2'b00, tap[0][0]} + {1'b0, tap[1][0], 1'b0} + {2'b00, tap[2][0]};
    sum_t = {2'b00, tap[0][0]} + {1'b0, tap[0][1], 1'b0} + {2'b00, tap[0][2]};
    sum_b = {2'b00, tap[2][0]} + {1'b0, tap[2][1], 1'b0} + {2'b00, tap[2][2]};
  end

  always_ff @(posedge clk) begin
    if (state == S_GRAD) begin
      ax_q <= quarter_abs(sum_r, sum_l);
      ay_q <= quarter_abs(sum_t, sum_b);
    end
  end

  // Sum of squares feeds the square-root unit.
  assign ax_sq      = ax_q * ax_q;
  assign ay_sq      = ay_q * ay_q;
  assign sq_sum     = {1'b0, ax_sq} + {1'b0, ay_sq};
  assign root_start = (state == S_SQ);

  sed_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .operand  (sq_sum),
    .done     (root_done),
    .root_rnd (root_rnd)
  );

  always_ff @(posedge clk) begin
    if (state == S_ROOT && root_done) begin
      mag_q <= (root_rnd > ROOT_W'(255)) ? '1 : root_rnd[PIX_W-1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && !ignore) state_next = S_GRAY;
      S_GRAY: state_next = S_WIN;
      S_WIN:  state_next = tag_q.valid ? S_GRAD : S_IDLE;
      S_GRAD: state_next = S_SQ;
      S_SQ:   state_next = S_ROOT;
      S_ROOT: if (root_done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      grad_x_abs <= ax_q;
      grad_y_abs <= ay_q;
      magnitude  <= mag_q;
      edge_res   <= (mag_q >= edge_level);
      frame_last <= tag_q.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_count} < eff_w))
    else $error("column counter past the image width");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, row_count} <= ({1'b0, eff_h} + (HGT_W+1)'(1))))
    else $error("row counter past the drain row");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && !ignore && tag_now.valid && tag_now.last && !geom_wr)
      |=> (col_count == '0 && row_count == '0))
    else $error("counters not cleared after the frame's last pixel");

  a_root_owner: assert property (@(posedge clk) disable iff (rst)
    root_done |-> (state == S_ROOT))
    else $error("square root finished outside its sequencer step");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");
`endif

endmodule

FILE: hdl/sed_root.sv
// ---------------------------------------------------------------------------
// sed_root: rounded integer square root
// Digit-by-digit square root; the result is rounded to
// the nearest integer using the final remainder.
// ---------------------------------------------------------------------------
module sed_root import sed_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ROOT_OP_W-1:0] operand,
  output logic                 done,
  output logic [ROOT_W-1:0]    root_rnd
);

  logic [ROOT_PAD_W-1:0] bits_q;
  logic [ROOT_REM_W-1:0] rem_q;
  logic [ROOT_W-1:0]     rt_q;
  logic [ROOT_CNT_W-1:0] cnt_q;
  logic                  done_q;

  logic [ROOT_PAD_W-1:0] bits_next;
  logic [ROOT_REM_W-1:0] rem_next;
  logic [ROOT_W-1:0]     rt_next;
  logic [ROOT_ACC_W-1:0] acc;
  logic [ROOT_ACC_W-1:0] trial;

  // Each pass brings down the next bit pair and tries to append a one.
  always_comb begin
    bits_next = bits_q;
    rem_next  = rem_q;
    rt_next   = rt_q;
    acc       = '0;
    trial     = '0;
    for (int j = 0; j < ROOT_PAIRS; j++) begin
      acc       = {rem_next, bits_next[ROOT_PAD_W-1 -: 2]};
      trial     = {{(ROOT_ACC_W-ROOT_W-2){1'b0}}, rt_next, 2'b01};
      bits_next = {bits_next[ROOT_PAD_W-3:0], 2'b00};
      if (acc >= trial) begin
        rem_next = ROOT_REM_W'(acc - trial);
        rt_next  = {rt_next[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next = acc[ROOT_REM_W-1:0];
        rt_next  = {rt_next[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start) begin
      bits_q <= {{(ROOT_PAD_W-ROOT_OP_W){1'b0}}, operand};
      rem_q  <= '0;
      rt_q   <= '0;
      cnt_q  <= ROOT_CNT_W'(ROOT_ITER);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == ROOT_CNT_W'(1));
      if (cnt_q != '0) begin
        bits_q <= bits_next;
        rem_q  <= rem_next;
        rt_q   <= rt_next;
        cnt_q  <= cnt_q - ROOT_CNT_W'(1);
      end
    end
  end

  // Round up when the operand lies above n*n + n.
  assign done     = done_q;
  assign root_rnd = rt_q + ROOT_W'(rem_q > {{(ROOT_REM_W-ROOT_W){1'b0}}, rt_q});

endmodule
